FILE: sv/contour_midpoint_inserter_unit_macros.svh
// Assertion macros shared by the contour midpoint inserter modules.
`ifndef CONTOUR_MIDPOINT_INSERTER_UNIT_MACROS_SVH
`define CONTOUR_MIDPOINT_INSERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define CMI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in the same cycle");

`define CMI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in the next cycle");

`else

`define CMI_ASSERT_SAME(label, clk, rst, ante, cons)

`define CMI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/cmi_pkg.sv
// Types, constants and the midpoint function of the contour midpoint inserter.
package cmi_pkg;

   localparam int COORD_W   = 16;
   localparam int FLAGS_W   = 8;
   localparam int NUM_SLOTS = 4;
   localparam int SLOT_W    = 2;
   localparam int JOB_DEPTH = 2;
   localparam int JOB_PTR_W = 1;
   localparam int JOB_CNT_W = 2;

   // Result slots of one job, in the order they leave the block.
   localparam logic [SLOT_W-1:0] SLOT_HELD  = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_MID_A = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_NEW   = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_MID_B = 2'd3;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [COORD_W-1:0]   held_x;
      logic [COORD_W-1:0]   held_y;
      logic [FLAGS_W-1:0]   held_flags;
      logic [COORD_W-1:0]   new_x;
      logic [COORD_W-1:0]   new_y;
      logic [FLAGS_W-1:0]   new_flags;
      logic                 new_end;
      logic [COORD_W-1:0]   start_x;
      logic [COORD_W-1:0]   start_y;
   } job_type;

   // Mean of two signed coordinates, truncated toward zero.
   function automatic logic [COORD_W-1:0] mid_coord(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
      logic [COORD_W:0] sum;
      logic [COORD_W:0] adj;
      sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      adj = sum + {{COORD_W{1'b0}}, sum[COORD_W]};
      return adj[COORD_W:1];
   endfunction

endpackage

FILE: sv/cmi_front.sv
// Front part: accepts points, tracks the held point and contour start, builds jobs.
module cmi_front import cmi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [COORD_W-1:0] req_point_x,
   input  logic [COORD_W-1:0] req_point_y,
   input  logic [FLAGS_W-1:0] req_point_flags,
   input  logic               req_ends_contour,
   input  logic               job_full,
   output logic               job_push,
   output job_type            job
);

   logic               held_valid_ff, held_valid_in;
   logic [COORD_W-1:0] held_x_ff, held_x_in;
   logic [COORD_W-1:0] held_y_ff, held_y_in;
   logic [FLAGS_W-1:0] held_flags_ff, held_flags_in;
   logic [COORD_W-1:0] start_x_ff, start_x_in;
   logic [COORD_W-1:0] start_y_ff, start_y_in;
   logic               start_on_ff, start_on_in;
   logic               accept;
   logic               new_on;
   logic               start_on_eff;

   assign full   = job_full;
   assign accept = push && !job_full;
   assign new_on = req_point_flags[0];

   always_comb begin
      start_on_eff = held_valid_ff ? start_on_ff : new_on;

      job.mask               = '0;
      job.mask[SLOT_HELD]    = held_valid_ff;
      job.mask[SLOT_MID_A]   = held_valid_ff && (held_flags_ff[0] == new_on);
      job.mask[SLOT_NEW]     = req_ends_contour;
      job.mask[SLOT_MID_B]   = req_ends_contour && (new_on == start_on_eff);
      job.held_x             = held_x_ff;
      job.held_y             = held_y_ff;
      job.held_flags         = held_flags_ff;
      job.new_x              = req_point_x;
      job.new_y              = req_point_y;
      job.new_flags          = req_point_flags;
      job.new_end            = req_ends_contour;
      job.start_x            = held_valid_ff ? start_x_ff : req_point_x;
      job.start_y            = held_valid_ff ? start_y_ff : req_point_y;

      job_push = accept && (held_valid_ff || req_ends_contour);

      held_valid_in = held_valid_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_flags_in = held_flags_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      start_on_in   = start_on_ff;
      if (accept) begin
         if (!held_valid_ff) begin
            start_x_in  = req_point_x;
            start_y_in  = req_point_y;
            start_on_in = new_on;
         end
         held_valid_in = !req_ends_contour;
         if (!req_ends_contour) begin
            held_x_in     = req_point_x;
            held_y_in     = req_point_y;
            held_flags_in = req_point_flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_x_ff     <= held_x_in;
      held_y_ff     <= held_y_in;
      held_flags_ff <= held_flags_in;
      start_x_ff    <= start_x_in;
      start_y_ff    <= start_y_in;
      start_on_ff   <= start_on_in;
   end

endmodule

FILE: sv/cmi_job_fifo.sv
// Short job queue between the front and back parts.
`include "contour_midpoint_inserter_unit_macros.svh"
module cmi_job_fifo import cmi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output job_type pop_job
);

   job_type                entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == JOB_CNT_W'(JOB_DEPTH));
   assign valid   = (count_ff != '0);
   assign pop_job = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + JOB_CNT_W'(do_push) - JOB_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `CMI_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= JOB_CNT_W'(JOB_DEPTH))
   `CMI_ASSERT_SAME(a_no_push_when_full, clock, reset, push, !full)

endmodule

FILE: sv/cmi_back.sv
// Back part: steps through the results of each job and keeps the result register.
`include "contour_midpoint_inserter_unit_macros.svh"
module cmi_back import cmi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  job_type            job_in_q,
   output logic               job_pop,
   output logic               out_valid,
   input  logic               out_take,
   output logic [COORD_W-1:0] out_x,
   output logic [COORD_W-1:0] out_y,
   output logic [FLAGS_W-1:0] out_flags,
   output logic               out_contour_end,
   output logic               out_last
);

   job_type              job_ff, job_in;
   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   logic                 valid_ff, valid_in;
   logic [COORD_W-1:0]   x_ff, x_in;
   logic [COORD_W-1:0]   y_ff, y_in;
   logic [FLAGS_W-1:0]   flags_ff, flags_in;
   logic                 end_ff, end_in;
   logic                 last_ff, last_in;
   logic [SLOT_W-1:0]    slot;
   logic [NUM_SLOTS-1:0] rest;
   logic                 emit;
   logic                 load;

   always_comb begin
      if (mask_ff[SLOT_HELD]) begin
         slot = SLOT_HELD;
      end else if (mask_ff[SLOT_MID_A]) begin
         slot = SLOT_MID_A;
      end else if (mask_ff[SLOT_NEW]) begin
         slot = SLOT_NEW;
      end else begin
         slot = SLOT_MID_B;
      end
      rest = mask_ff & ~(NUM_SLOTS'(1) << slot);
      emit = (mask_ff != '0) && (!valid_ff || out_take);
      load = job_valid && ((mask_ff == '0) || (emit && (rest == '0)));

      job_in  = load ? job_in_q : job_ff;
      mask_in = load ? job_in_q.mask : (emit ? rest : mask_ff);

      case (slot)
         SLOT_HELD: begin
            x_in     = job_ff.held_x;
            y_in     = job_ff.held_y;
            flags_in = job_ff.held_flags;
         end
         SLOT_MID_A: begin
            x_in     = mid_coord(job_ff.held_x, job_ff.new_x);
            y_in     = mid_coord(job_ff.held_y, job_ff.new_y);
            flags_in = {{(FLAGS_W-1){1'b0}}, ~job_ff.held_flags[0]};
         end
         SLOT_NEW: begin
            x_in     = job_ff.new_x;
            y_in     = job_ff.new_y;
            flags_in = job_ff.new_flags;
         end
         default: begin
            x_in     = mid_coord(job_ff.new_x, job_ff.start_x);
            y_in     = mid_coord(job_ff.new_y, job_ff.start_y);
            flags_in = {{(FLAGS_W-1){1'b0}}, ~job_ff.new_flags[0]};
         end
      endcase
      last_in = (rest == '0);
      end_in  = job_ff.new_end && (rest == '0);

      if (emit) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign job_pop         = load;
   assign out_valid       = valid_ff;
   assign out_x           = x_ff;
   assign out_y           = y_ff;
   assign out_flags       = flags_ff;
   assign out_contour_end = end_ff;
   assign out_last        = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         flags_ff <= flags_in;
         end_ff   <= end_in;
         last_ff  <= last_in;
      end
   end

   `CMI_ASSERT_NEXT(a_busy_fills_output, clock, reset, (mask_ff != '0) && !valid_ff, valid_ff)
   `CMI_ASSERT_NEXT(a_load_takes_mask, clock, reset, load, mask_ff == $past(job_in_q.mask))
   `CMI_ASSERT_SAME(a_end_is_last, clock, reset, valid_ff && end_ff, last_ff)

endmodule

FILE: sv/contour_midpoint_inserter_unit.sv
// Top level of the contour midpoint inserter: front part, job queue and back part.
// Jobs pass through the queue and the back part's job register into the result register.
// Throughput: one result beat per cycle from the back part while results are popped;
// a point yields zero to four. A point is taken every cycle while the two-entry job
// queue has room, with typically one or two results each.
// Reset clears the held point, the job queue and the result register; nothing is held.
module contour_midpoint_inserter_unit import cmi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [COORD_W-1:0] req_point_x,
   input  logic [COORD_W-1:0] req_point_y,
   input  logic [FLAGS_W-1:0] req_point_flags,
   input  logic               req_ends_contour,
   output logic               empty,
   input  logic               pop,
   output logic [COORD_W-1:0] rsp_out_x,
   output logic [COORD_W-1:0] rsp_out_y,
   output logic [FLAGS_W-1:0] rsp_out_flags,
   output logic               rsp_out_contour_end,
   output logic               rsp_last_of_run
);

   job_type front_job;
   job_type queue_job;
   logic    job_push;
   logic    job_full;
   logic    job_valid;
   logic    job_pop;
   logic    out_valid;
   logic    out_take;

   assign empty    = !out_valid;
   assign out_take = pop && out_valid;

   cmi_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_flags  (req_point_flags),
      .req_ends_contour (req_ends_contour),
      .job_full         (job_full),
      .job_push         (job_push),
      .job              (front_job)
   );

   cmi_job_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (job_full),
      .pop      (job_pop),
      .valid    (job_valid),
      .pop_job  (queue_job)
   );

   cmi_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job_in_q        (queue_job),
      .job_pop         (job_pop),
      .out_valid       (out_valid),
      .out_take        (out_take),
      .out_x           (rsp_out_x),
      .out_y           (rsp_out_y),
      .out_flags       (rsp_out_flags),
      .out_contour_end (rsp_out_contour_end),
      .out_last        (rsp_last_of_run)
   );

endmodule
